>>> rtl/stkt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stkt_pkg
// Shared types, constants and helpers of the second-based tick timekeeper.
// ----------------------------------------------------------------------------
package stkt_pkg;

  localparam int unsigned CNT_W   = 32;  // width of every running count
  localparam int unsigned TICK_W  = 31;  // reported tick width
  localparam int unsigned CLK_W   = 32;  // core clock register width

  localparam logic [CLK_W-1:0] CLK_HZ_RST = 32'd48000000;

  localparam logic [CNT_W-1:0] MS_PER_S = 32'd1000;
  localparam logic [CNT_W-1:0] US_PER_S = 32'd1000000;

  // Multiplier for cycle count to microsecond scaling (20 bits are enough)
  localparam int unsigned      USK_W    = 20;
  localparam logic [USK_W-1:0] US_K     = 20'd1000000;
  localparam int unsigned      PROD_W   = CNT_W + USK_W;  // dividend width

  // Reciprocal of 1000: x / 1000 == (x * RECIP_K) >> RECIP_SH for 32-bit x
  localparam int unsigned       RECIP_W  = 29;
  localparam logic [RECIP_W-1:0] RECIP_K = 29'd274877907;
  localparam int unsigned       RECIP_SH = 38;
  localparam int unsigned       MSP_W    = CNT_W + RECIP_W;

  // Restoring divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned DIVC_W    = $clog2(DIV_STEPS);

  // Decoupling queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Counter state after one item, as handed to the back end
  typedef struct packed {
    logic [CNT_W-1:0] cycle;
    logic [CNT_W-1:0] sec;
    logic [CNT_W-1:0] milli;
    logic [CNT_W-1:0] micro;
  } stkt_snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stkt_qstat_t;

  typedef struct packed {
    logic busy;
  } stkt_bstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SCALE,
    ST_SUM
  } stkt_state_e;

  // A zero frequency behaves as one
  function automatic logic [CLK_W-1:0] stkt_eff_clk(input logic [CLK_W-1:0] hz);
    return (hz == '0) ? CLK_W'(1) : hz;
  endfunction

endpackage
`default_nettype wire

>>> rtl/stkt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stkt_front
// Accepts items, holds the clock register and advances the running counts.
// ----------------------------------------------------------------------------
module stkt_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic                     advance_i,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [stkt_pkg::CLK_W-1:0] core_clock_hz_i,
  output logic [stkt_pkg::CLK_W-1:0]    clk_hz_o,
  input  wire stkt_pkg::stkt_qstat_t    q_stat_i,
  output logic                          q_push_o,
  output stkt_pkg::stkt_snap_t          q_data_o
);
  import stkt_pkg::*;

  logic [CLK_W-1:0] clk_hz_q;
  stkt_snap_t       cnt_q, cnt_d;
  logic [CLK_W-1:0] eff;
  logic             accept;
  logic             wrap;

  assign cfg_ready_o = 1'b1;
  assign clk_hz_o    = clk_hz_q;
  assign full        = q_stat_i.full;
  assign accept      = push && !full;
  assign eff         = stkt_eff_clk(clk_hz_q);
  assign wrap        = cnt_q.cycle >= (eff - CLK_W'(1));

  // Advance the counts; complete a second at the wrap point
  always_comb begin
    cnt_d = cnt_q;
    if (advance_i) begin
      if (wrap) begin
        cnt_d.cycle = '0;
        cnt_d.sec   = cnt_q.sec + CNT_W'(1);
        cnt_d.milli = cnt_q.milli + MS_PER_S;
        cnt_d.micro = cnt_q.micro + US_PER_S;
      end else begin
        cnt_d.cycle = cnt_q.cycle + CNT_W'(1);
      end
    end
  end

  assign q_push_o = accept;
  assign q_data_o = cnt_d;

  // Hold the clock register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= CLK_HZ_RST;
    end else if (cfg_valid_i) begin
      clk_hz_q <= core_clock_hz_i;
    end
  end

  // Update the counts on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/stkt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stkt_queue
// Short first-in first-out queue of count snapshots between front and back.
// ----------------------------------------------------------------------------
module stkt_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire stkt_pkg::stkt_snap_t  data_i,
  input  wire logic                  pop_i,
  output stkt_pkg::stkt_snap_t       data_o,
  output stkt_pkg::stkt_qstat_t      stat_o
);
  import stkt_pkg::*;

  stkt_snap_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  // Store the item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/stkt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stkt_back
// Converts the cycle count to sub-second ticks and forms the result item.
// ----------------------------------------------------------------------------
module stkt_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [stkt_pkg::CLK_W-1:0] clk_hz_i,
  input  wire stkt_pkg::stkt_qstat_t      q_stat_i,
  input  wire stkt_pkg::stkt_snap_t       q_data_i,
  output logic                            q_pop_o,
  output stkt_pkg::stkt_bstat_t           stat_o,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [stkt_pkg::CNT_W-1:0]      seconds_o,
  output logic [stkt_pkg::TICK_W-1:0]     ms_ticks_o,
  output logic [stkt_pkg::TICK_W-1:0]     us_ticks_o
);
  import stkt_pkg::*;

  stkt_state_e       state_q, state_d;
  stkt_snap_t        snap_q;
  logic [PROD_W-1:0] prod_q;
  logic [CNT_W-1:0]  rem_q;
  logic [DIVC_W-1:0] step_q;
  logic [MSP_W-1:0]  msp_q;
  logic [CNT_W-1:0]  off_q;
  logic              out_valid_q;

  logic [CLK_W-1:0]  eff;
  logic [CLK_W:0]    rem_sh;
  logic              ge;
  logic              out_load;
  logic [CNT_W-1:0]  ms_sum, us_sum;

  assign eff    = stkt_eff_clk(clk_hz_i);
  assign rem_sh = {rem_q, prod_q[PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, eff};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (!q_stat_i.empty) state_d = ST_MUL;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   if (step_q == DIVC_W'(DIV_STEPS - 1)) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_SUM;
      ST_SUM:   if (!out_valid_q || pop) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop_o     = 1'b0;
    out_load    = 1'b0;
    stat_o.busy = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        q_pop_o     = !q_stat_i.empty;
        stat_o.busy = 1'b0;
      end
      ST_SUM:   out_load = !out_valid_q || pop;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIV) begin
        step_q <= step_q + DIVC_W'(1);
      end else begin
        step_q <= '0;
      end
    end
  end

  // Datapath: scale, divide one bit per cycle, then split off milliseconds
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o) snap_q <= q_data_i;
      end
      ST_MUL: begin
        prod_q <= snap_q.cycle * US_K;
        rem_q  <= '0;
      end
      ST_DIV: begin
        rem_q  <= ge ? CNT_W'(rem_sh - {1'b0, eff}) : rem_sh[CNT_W-1:0];
        prod_q <= {prod_q[PROD_W-2:0], ge};
      end
      ST_SCALE: begin
        off_q <= prod_q[CNT_W-1:0];
        msp_q <= prod_q[CNT_W-1:0] * RECIP_K;
      end
      default: ;
    endcase
  end

  assign ms_sum = snap_q.milli + CNT_W'(msp_q[MSP_W-1:RECIP_SH]);
  assign us_sum = snap_q.micro + off_q;

  // Hold the finished result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      seconds_o  <= snap_q.sec;
      ms_ticks_o <= ms_sum[TICK_W-1:0];
      us_ticks_o <= us_sum[TICK_W-1:0];
    end
  end

  assign empty = !out_valid_q;

endmodule
`default_nettype wire

>>> rtl/second_based_tick_timekeeper_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// second_based_tick_timekeeper_unit
// Second-based timekeeper reporting seconds and millisecond/microsecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Push one item per core clock cycle (advance_i high counts the cycle).
//   The front end updates the cycle, second, milli and micro counts as the
//   item is accepted and queues a snapshot (two entries deep). The back end
//   turns the cycle count into a microsecond offset with a 32x20 multiply and
//   a restoring divide by the clock frequency, one quotient bit per cycle,
//   then splits off milliseconds with a reciprocal multiply.
//   A result shows when empty goes low. The back end takes one item at a
//   time from the queue and runs its cycle count through the 52-step
//   divider. full rises once the queue holds two items.
//   Results wait in an output register while the receiver does not pop;
//   the back end keeps working and stalls only at its final step.
//   core_clock_hz is written through cfg_valid_i, always ready; write it
//   only while no item is in flight. Reset clears all counts, empties the
//   queue and sets the frequency to 48 MHz.
// ----------------------------------------------------------------------------
module second_based_tick_timekeeper_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       advance_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [stkt_pkg::CNT_W-1:0]      seconds_o,
  output logic [stkt_pkg::TICK_W-1:0]     ms_ticks_o,
  output logic [stkt_pkg::TICK_W-1:0]     us_ticks_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [stkt_pkg::CLK_W-1:0] core_clock_hz_i
);
  import stkt_pkg::*;

  logic [CLK_W-1:0] clk_hz;
  stkt_qstat_t      q_stat;
  stkt_bstat_t      bk_stat;
  stkt_snap_t       q_wdata, q_rdata;
  logic             q_push, q_pop;

  stkt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .advance_i       (advance_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .core_clock_hz_i (core_clock_hz_i),
    .clk_hz_o        (clk_hz),
    .q_stat_i        (q_stat),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata)
  );

  stkt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  stkt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clk_hz_i   (clk_hz),
    .q_stat_i   (q_stat),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .stat_o     (bk_stat),
    .empty      (empty),
    .pop        (pop),
    .seconds_o  (seconds_o),
    .ms_ticks_o (ms_ticks_o),
    .us_ticks_o (us_ticks_o)
  );

  // A result appears only at the end of back-end work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(bk_stat.busy))
    else $error("result appeared without back-end work");

  // An idle back end picks up a waiting item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_stat.empty && !bk_stat.busy) |=> bk_stat.busy)
    else $error("back end ignored a queued item");

  // An accepted item lands in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !q_stat.empty)
    else $error("accepted item lost before the queue");

endmodule
`default_nettype wire

>>> tb/sv/second_based_tick_timekeeper_unit_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// second_based_tick_timekeeper_unit_chk
// Watches the item, result and clock-register channels of the timekeeper,
// predicts the tick report for every accepted item and compares each popped
// result field by field against the oldest pending report.
// ----------------------------------------------------------------------------
module second_based_tick_timekeeper_unit_chk (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic                       full_i,
  input  wire logic                       advance_i,
  input  wire logic                       empty_i,
  input  wire logic                       pop_i,
  input  wire logic [stkt_pkg::CNT_W-1:0] seconds_i,
  input  wire logic [stkt_pkg::TICK_W-1:0] ms_ticks_i,
  input  wire logic [stkt_pkg::TICK_W-1:0] us_ticks_i,
  input  wire logic                       cfg_valid_i,
  input  wire logic                       cfg_ready_i,
  input  wire logic [stkt_pkg::CLK_W-1:0] core_clock_hz_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  import stkt_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0]  seconds;
    logic [TICK_W-1:0] ms_ticks;
    logic [TICK_W-1:0] us_ticks;
  } tick_report_t;

  // Shadow copy of the timekeeper state and its clock register
  logic [CLK_W-1:0] clock_hz;
  logic [CNT_W-1:0] cycle_cnt;
  logic [CNT_W-1:0] sec_cnt;
  logic [CNT_W-1:0] milli_cnt;
  logic [CNT_W-1:0] micro_cnt;

  tick_report_t reports_due[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Advance the shadow counts by one item and build the tick report
  function automatic tick_report_t count_cycle(input logic adv);
    tick_report_t     rep;
    logic [CLK_W-1:0] period;
    logic [63:0]      scaled;
    logic [CNT_W-1:0] offset_us;
    logic [CNT_W-1:0] ms_sum;
    logic [CNT_W-1:0] us_sum;
    period = (clock_hz == '0) ? 32'd1 : clock_hz;
    if (adv) begin
      // a count at or past the limit closes the second
      if (cycle_cnt >= period - 32'd1) begin
        cycle_cnt = '0;
        sec_cnt   = sec_cnt + 32'd1;
        milli_cnt = milli_cnt + MS_PER_S;
        micro_cnt = micro_cnt + US_PER_S;
      end else begin
        cycle_cnt = cycle_cnt + 32'd1;
      end
    end
    // sub-second offset, quotient cut to 32 bits
    scaled    = {32'd0, cycle_cnt} * {32'd0, US_PER_S};
    scaled    = scaled / {32'd0, period};
    offset_us = scaled[CNT_W-1:0];
    ms_sum    = milli_cnt + offset_us / MS_PER_S;
    us_sum    = micro_cnt + offset_us;
    rep.seconds  = sec_cnt;
    rep.ms_ticks = ms_sum[TICK_W-1:0];
    rep.us_ticks = us_sum[TICK_W-1:0];
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_report_t want;
    if (!rst_ni) begin
      clock_hz  = CLK_HZ_RST;
      cycle_cnt = '0;
      sec_cnt   = '0;
      milli_cnt = '0;
      micro_cnt = '0;
      reports_due.delete();
    end else begin
      // compare a popped result with the oldest report
      if (pop_i && !empty_i) begin
        if (reports_due.size() == 0) begin
          $error("result popped with no item pending: seconds %0d", seconds_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = reports_due.pop_front();
          if (seconds_i !== want.seconds) begin
            $error("seconds mismatch: expected %0d, actual %0d", want.seconds, seconds_i);
            fail_count_o = fail_count_o + 1;
          end
          if (ms_ticks_i !== want.ms_ticks) begin
            $error("ms_ticks mismatch: expected %0d, actual %0d", want.ms_ticks,
                   ms_ticks_i);
            fail_count_o = fail_count_o + 1;
          end
          if (us_ticks_i !== want.us_ticks) begin
            $error("us_ticks mismatch: expected %0d, actual %0d", want.us_ticks,
                   us_ticks_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      // predict the report of an accepted item
      if (push_i && !full_i) begin
        reports_due.push_back(count_cycle(advance_i));
      end
      // track clock register writes
      if (cfg_valid_i && cfg_ready_i) begin
        clock_hz = core_clock_hz_i;
      end
    end
    pending_o = reports_due.size();
  end

endmodule
`default_nettype wire

>>> tb/sv/second_based_tick_timekeeper_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// second_based_tick_timekeeper_unit_tb
// Drives core clock items and clock register writes into the timekeeper:
// a directed run through zero and tiny clocks and a lowered limit, random
// phases over many clock settings with bursty idling and one long receiver
// hold-off, and a short count at the widest clock read back past the limit.
// ----------------------------------------------------------------------------
module second_based_tick_timekeeper_unit_tb;

  import stkt_pkg::*;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                push            = 1'b0;
  logic                advance_i       = 1'b0;
  logic                pop             = 1'b0;
  logic                cfg_valid_i     = 1'b0;
  logic [CLK_W-1:0]    core_clock_hz_i = '0;
  logic                full;
  logic                empty;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    seconds_o;
  logic [TICK_W-1:0]   ms_ticks_o;
  logic [TICK_W-1:0]   us_ticks_o;
  int                  fail_count;
  int                  pending;

  // idling control shared by sender and receiver
  bit                  idle_en  = 1'b1;
  bit                  hold_req = 1'b0;

  second_based_tick_timekeeper_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .advance_i       (advance_i),
    .empty           (empty),
    .pop             (pop),
    .seconds_o       (seconds_o),
    .ms_ticks_o      (ms_ticks_o),
    .us_ticks_o      (us_ticks_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .core_clock_hz_i (core_clock_hz_i)
  );

  second_based_tick_timekeeper_unit_chk u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .advance_i       (advance_i),
    .empty_i         (empty),
    .pop_i           (pop),
    .seconds_i       (seconds_o),
    .ms_ticks_i      (ms_ticks_o),
    .us_ticks_i      (us_ticks_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .core_clock_hz_i (core_clock_hz_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Backstop against a hung run
  initial begin
    #15000000;
    $display("Test completed with failures");
    $finish;
  end

  // Pop results, with random stall bursts and one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop      <= 1'b0;
        hold_req  = 1'b0;
        repeat (300) @(negedge clk_i);
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offer one item; entered and left just after a falling edge
  task automatic send_cycle(input logic adv);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    push      <= 1'b1;
    advance_i <= adv;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop push, drain every pending result, then write the clock register
  task automatic set_core_clock(input logic [CLK_W-1:0] hz);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    core_clock_hz_i <= hz;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random phase: set the clock, then mostly advancing items
  task automatic run_phase(input logic [CLK_W-1:0] hz, input int n_items,
                           input bit hold);
    set_core_clock(hz);
    if (hold) hold_req = 1'b1;
    repeat (n_items) send_cycle($urandom_range(0, 3) != 0);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset clock: hold and advance
    send_cycle(1'b0);
    send_cycle(1'b1);
    send_cycle(1'b1);
    send_cycle(1'b0);
    // zero clock: every advance closes a second
    set_core_clock(32'd0);
    send_cycle(1'b1);
    send_cycle(1'b1);
    send_cycle(1'b0);
    send_cycle(1'b1);
    // 1 Hz clock: each advance closes a second
    set_core_clock(32'd1);
    send_cycle(1'b1);
    send_cycle(1'b0);
    send_cycle(1'b1);
    // short second with wraps
    set_core_clock(32'd3);
    repeat (5) send_cycle(1'b1);
    // build a count, then lower the limit below it
    set_core_clock(32'd100);
    repeat (6) send_cycle(1'b1);
    set_core_clock(32'd4);
    send_cycle(1'b0);
    send_cycle(1'b1);

    // random phases over many clock settings
    run_phase(32'd1, 100, 1'b0);
    run_phase(32'd0, 80, 1'b0);
    run_phase(32'd2, 100, 1'b0);
    run_phase(32'd7, 120, 1'b1);
    run_phase(32'd1000, 100, 1'b0);
    run_phase(32'hFFFF_FFFF, 80, 1'b0);
    run_phase($urandom, 80, 1'b0);
    run_phase($urandom_range(1, 64), 100, 1'b0);
    idle_en = 1'b0;
    run_phase(CLK_HZ_RST, 90, 1'b0);

    // short count at the widest clock, then read it back past the limit
    set_core_clock(32'hFFFF_FFFF);
    repeat (20) send_cycle(1'b1);
    set_core_clock(32'd1);
    send_cycle(1'b0);
    send_cycle(1'b0);
    send_cycle(1'b1);
    send_cycle(1'b1);
    set_core_clock(32'd0);
    send_cycle(1'b1);
    send_cycle(1'b0);
    push <= 1'b0;

    // drain and let the back end settle
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/stkt_pkg.sv
rtl/stkt_front.sv
rtl/stkt_queue.sv
rtl/stkt_back.sv
rtl/second_based_tick_timekeeper_unit.sv
tb/sv/second_based_tick_timekeeper_unit_chk.sv
tb/sv/second_based_tick_timekeeper_unit_tb.sv
